// File: sv/cstc_pkg.sv
package cstc_pkg;

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int MaxSlots  = 4;

  localparam logic REG_PERIOD    = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_GT = 8'h3E;

  localparam logic [7:0] CTRL_LOW  = 8'd32;
  localparam logic [7:0] CTRL_HIGH = 8'd127;

  typedef struct packed {
    logic [7:0] value;
    logic       has;
    logic       ctrl;
    logic       stat;
    logic       last;
  } slot_t;

  // One command holds every result that a single input item causes,
  // slot 0 first.
  typedef struct packed {
    logic [2:0]                cnt;
    slot_t [MaxSlots-1:0]      slot;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// File: sv/cyclic_shift_text_codec_core.sv
// Cyclic shift text codec: codes the body of a text one byte per input
// transfer, in either direction as set by the direction register, with a
// period register for the shift cycle and newline grouping. The block
// takes one input item per clock cycle unless in_stall is raised. An item
// gives zero to four results; each result leaves in a transfer of its own,
// so the output side sets the sustained rate at one result per cycle while
// out_stall is low, and items that expand (a newline when encoding, broken
// markers when decoding) hold the input back only once the four-entry
// command queue between front and back has filled. The first result of an
// item passes through the command queue and then the output register before
// it appears at the output. Write the registers only while the block is idle.
module cyclic_shift_text_codec_core import cstc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       ctrl_char,
  output logic       status,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  fifo_status_t fifo_st;
  logic         push;
  logic         pop;
  cmd_t         push_cmd;
  cmd_t         pop_cmd;

  cstc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fifo_st     (fifo_st),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  cstc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (fifo_st)
  );

  cstc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_st   (fifo_st),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .ctrl_char (ctrl_char),
    .status    (status),
    .last      (last)
  );

endmodule

// File: sv/cstc_front.sv
module cstc_front import cstc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         end_of_text,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  input  fifo_status_t fifo_st,
  output logic         push,
  output cmd_t         push_cmd
);

  logic [7:0] period;
  logic       direction;
  logic [7:0] shift_step, shift_step_next;
  logic [7:0] nl_count, nl_count_next;
  logic [1:0] held, held_next;
  logic [7:0] recent0, recent0_next;
  logic [7:0] recent1, recent1_next;
  logic       err, err_next;
  logic       accept;

  function automatic logic [7:0] cur_step(input logic [7:0] sc, input logic [7:0] per);
    return (sc == 8'd0 || sc > per) ? 8'd1 : sc;
  endfunction

  function automatic logic [7:0] adv_step(input logic [7:0] s);
    return (s == 8'hFF) ? 8'd1 : s + 8'd1;
  endfunction

  function automatic logic [7:0] shift_byte(input logic [7:0] b, input logic [7:0] s,
                                            input logic up_on_odd);
    logic [8:0] sum;
    logic [7:0] mag;
    sum = {1'b0, s} + 9'd1;
    mag = sum[8:1];
    return (s[0] == up_on_odd) ? b + mag : b - mag;
  endfunction

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < CTRL_LOW) || (b >= CTRL_HIGH);
  endfunction

  function automatic slot_t mk_slot(input logic [7:0] v, input logic h, input logic c,
                                    input logic s, input logic l);
    slot_t r;
    r.value = v;
    r.has   = h;
    r.ctrl  = c;
    r.stat  = s;
    r.last  = l;
    return r;
  endfunction

  cmd_t       cmd;
  logic [2:0] k;
  logic [7:0] st, s, c, nl_sat;
  logic       amb, go;

  always_comb begin
    cmd             = '0;
    k               = 3'd0;
    st              = shift_step;
    s               = 8'd0;
    c               = 8'd0;
    nl_sat          = 8'd0;
    amb             = 1'b0;
    go              = 1'b0;
    shift_step_next = shift_step;
    nl_count_next   = nl_count;
    held_next       = held;
    recent0_next    = recent0;
    recent1_next    = recent1;
    err_next        = err;

    if (direction) begin
      if (end_of_text) begin
        if (!err) begin
          cmd.slot[0] = mk_slot(CH_LF, 1'b1, 1'b0, 1'b0, 1'b1);
          k = 3'd1;
        end
      end else if (!err) begin
        if (data_byte == CH_LF) begin
          cmd.slot[0] = mk_slot(CH_LT, 1'b1, 1'b0, 1'b0, 1'b0);
          cmd.slot[1] = mk_slot(CH_E,  1'b1, 1'b0, 1'b0, 1'b0);
          cmd.slot[2] = mk_slot(CH_GT, 1'b1, 1'b0, 1'b0, 1'b0);
          k = 3'd3;
          nl_sat = (nl_count == 8'hFF) ? nl_count : nl_count + 8'd1;
          if (nl_sat >= period) begin
            cmd.slot[3]   = mk_slot(CH_LF, 1'b1, 1'b0, 1'b0, 1'b0);
            k             = 3'd4;
            nl_count_next = 8'd0;
            recent1_next  = CH_GT;
            recent0_next  = CH_LF;
          end else begin
            nl_count_next = nl_sat;
            recent1_next  = CH_E;
            recent0_next  = CH_GT;
          end
        end else begin
          s   = cur_step(shift_step, period);
          c   = shift_byte(data_byte, s, 1'b1);
          amb = (c == CH_LF) || (recent1 == CH_LT && recent0 == CH_E && c == CH_GT);
          shift_step_next = adv_step(s);
          recent1_next    = recent0;
          recent0_next    = c;
          cmd.slot[0]     = mk_slot(c, 1'b1, is_ctrl(data_byte), amb, amb);
          k               = 3'd1;
          err_next        = amb;
        end
      end
    end else begin
      if (end_of_text) begin
        // Held marker bytes turn out to be ordinary characters.
        if (held >= 2'd1) begin
          s  = cur_step(st, period);
          c  = shift_byte(CH_LT, s, 1'b0);
          cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
          k  = k + 3'd1;
          st = adv_step(s);
        end
        if (held >= 2'd2) begin
          s  = cur_step(st, period);
          c  = shift_byte(CH_E, s, 1'b0);
          cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
          k  = k + 3'd1;
          st = adv_step(s);
        end
        if (k == 3'd0) begin
          cmd.slot[0] = mk_slot(8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
          k = 3'd1;
        end else begin
          cmd.slot[k[1:0] - 2'd1].last = 1'b1;
        end
      end else begin
        go = 1'b1;
        if (held == 2'd1) begin
          if (data_byte == CH_E) begin
            held_next = 2'd2;
            go        = 1'b0;
          end else begin
            s  = cur_step(st, period);
            c  = shift_byte(CH_LT, s, 1'b0);
            cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
            k  = k + 3'd1;
            st = adv_step(s);
            held_next = 2'd0;
          end
        end else if (held >= 2'd2) begin
          held_next = 2'd0;
          if (data_byte == CH_GT) begin
            cmd.slot[0] = mk_slot(CH_LF, 1'b1, 1'b0, 1'b0, 1'b0);
            k  = 3'd1;
            go = 1'b0;
          end else begin
            s  = cur_step(st, period);
            c  = shift_byte(CH_LT, s, 1'b0);
            cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
            k  = k + 3'd1;
            st = adv_step(s);
            s  = cur_step(st, period);
            c  = shift_byte(CH_E, s, 1'b0);
            cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
            k  = k + 3'd1;
            st = adv_step(s);
          end
        end
        if (go) begin
          if (data_byte == CH_LT) begin
            held_next = 2'd1;
          end else if (data_byte != CH_LF) begin
            s  = cur_step(st, period);
            c  = shift_byte(data_byte, s, 1'b0);
            cmd.slot[k[1:0]] = mk_slot(c, 1'b1, is_ctrl(c), 1'b0, 1'b0);
            k  = k + 3'd1;
            st = adv_step(s);
          end
        end
        shift_step_next = st;
      end
    end

    // End of text starts the next text from a clean state in both directions.
    if (end_of_text) begin
      shift_step_next = 8'd1;
      nl_count_next   = 8'd0;
      held_next       = 2'd0;
      recent0_next    = 8'd0;
      recent1_next    = 8'd0;
      err_next        = 1'b0;
    end
    cmd.cnt = k;
  end

  assign in_stall = fifo_st.full;
  assign accept   = in_valid && !fifo_st.full;
  assign push     = accept && (k != 3'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= 8'd6;
      direction  <= 1'b0;
      shift_step <= 8'd1;
      nl_count   <= 8'd0;
      held       <= 2'd0;
      recent0    <= 8'd0;
      recent1    <= 8'd0;
      err        <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERIOD) begin
          period <= cfg_data;
        end else begin
          direction <= cfg_data[0];
        end
      end
      if (accept) begin
        shift_step <= shift_step_next;
        nl_count   <= nl_count_next;
        held       <= held_next;
        recent0    <= recent0_next;
        recent1    <= recent1_next;
        err        <= err_next;
      end
    end
  end

  a_no_output_after_error: assert property (@(posedge clk) disable iff (rst)
    (accept && direction && err && !end_of_text) |-> !push)
    else $error("result produced after an ambiguity error");

  a_error_ends_text: assert property (@(posedge clk) disable iff (rst)
    (push && push_cmd.slot[0].stat) |-> (push_cmd.cnt == 3'd1 && push_cmd.slot[0].last))
    else $error("ambiguity result is not the single final result");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (held == 2'd0 && !err && shift_step == 8'd1))
    else $error("end of text did not clear the text state");

endmodule

// File: sv/cstc_fifo.sv
module cstc_fifo import cstc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         pop_cmd,
  output fifo_status_t status
);

  cmd_t            store [FifoDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign status.full  = (count == CntW'(FifoDepth));
  assign status.empty = (count == '0);
  assign pop_cmd      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FifoDepth))
    else $error("queue occupancy out of range");

endmodule

// File: sv/cstc_back.sv
module cstc_back import cstc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  fifo_status_t fifo_st,
  input  cmd_t         pop_cmd,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic         has_byte,
  output logic         ctrl_char,
  output logic         status,
  output logic         last
);

  cmd_t cur;
  logic cur_valid;
  logic take;
  logic need;

  assign take = cur_valid && !out_stall;
  // A new command is needed once the present one has handed over its final result.
  assign need = !cur_valid || (take && cur.cnt == 3'd1);
  assign pop  = need && !fifo_st.empty;

  assign out_valid = cur_valid;
  assign out_byte  = cur.slot[0].value;
  assign has_byte  = cur.slot[0].has;
  assign ctrl_char = cur.slot[0].ctrl;
  assign status    = cur.slot[0].stat;
  assign last      = cur.slot[0].last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_cmd;
    end else if (take) begin
      cur.cnt  <= cur.cnt - 3'd1;
      for (int i = 0; i < MaxSlots - 1; i++) begin
        cur.slot[i] <= cur.slot[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (need) begin
      cur_valid <= !fifo_st.empty;
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.cnt != 3'd0 && cur.cnt <= 3'(MaxSlots)))
    else $error("active command holds no results");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.slot[0].last) |-> (cur.cnt == 3'd1))
    else $error("final flag before the end of a command");

  a_empty_result_is_final: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !cur.slot[0].has) |-> (cur.slot[0].last && cur.slot[0].value == 8'd0))
    else $error("result without a byte that is not the final one");

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cstc_pkg::*;

  localparam logic DIR_DECODE    = 1'b0;
  localparam logic DIR_ENCODE    = 1'b1;

  localparam int SettleCycles = 6;
  localparam int LongHold     = 60;
  localparam int QuietLimit   = 2000;
  localparam int PhaseItems   = 18;

  typedef enum logic [1:0] {ROW_ITEM, ROW_PERIOD, ROW_DIRECTION} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       eot;
    logic       pinned;
    slot_t      want;
  } row_t;

  localparam int NumRows = 31;
  localparam row_t Plan [NumRows] = '{
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, 8'h41, 1'b0, 1'b1, '{8'h40, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_LT, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_E,  1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_GT, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_LT, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h78, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_LF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_LT, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_E,  1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_DIRECTION, 8'(DIR_ENCODE), 1'b0, 1'b0, '0},
    '{ROW_PERIOD, 8'd1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b1, '{CH_LF, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, CH_LF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h3B, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h44, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h3D, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h41, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_ITEM, 8'h09, 1'b0, 1'b1, '{CH_LF, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_PERIOD, 8'd0, 1'b0, 1'b0, '0},
    '{ROW_ITEM, CH_LF, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, '0},
    '{ROW_PERIOD, 8'd255, 1'b0, 1'b0, '0},
    '{ROW_DIRECTION, 8'(DIR_DECODE), 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h80, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       ctrl_char;
  logic       status;
  logic       last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  // Typed-in expectation travelling with the item it belongs to.
  logic  pin_valid = 1'b0;
  slot_t pin_result = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int coded_items = 0;
  int checked_results = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Shadow of the codec state and its registers.
  logic [7:0] period_reg;
  logic       encode_mode;
  logic [7:0] step_no;
  logic [7:0] lf_marks;
  logic [1:0] marker_held;
  logic [7:0] prev_newest;
  logic [7:0] prev_older;
  logic       enc_halted;

  slot_t item_results[$];
  slot_t expected_out[$];

  always #4ns clk = ~clk;

  cyclic_shift_text_codec_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .ctrl_char  (ctrl_char),
    .status     (status),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [7:0] live_step();
    return (step_no == 8'd0 || step_no > period_reg) ? 8'd1 : step_no;
  endfunction

  function automatic logic [7:0] rotate_char(input logic [7:0] b, input logic [7:0] s,
                                             input logic up_on_odd);
    logic [7:0] mag;
    mag = 8'((9'(s) + 9'd1) >> 1);
    return (s[0] == up_on_odd) ? b + mag : b - mag;
  endfunction

  function automatic logic is_ctrl_char(input logic [7:0] c);
    return (c < CTRL_LOW) || (c >= CTRL_HIGH);
  endfunction

  task automatic bump_step(input logic [7:0] s);
    step_no = (s == 8'd255) ? 8'd1 : s + 8'd1;
  endtask

  task automatic clear_text();
    step_no = 8'd1;
    lf_marks = 8'd0;
    marker_held = 2'd0;
    prev_newest = 8'h00;
    prev_older = 8'h00;
    enc_halted = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] b);
    logic [7:0] s;
    logic [7:0] c;
    s = live_step();
    c = rotate_char(b, s, 1'b0);
    bump_step(s);
    item_results.push_back(slot_t'{c, 1'b1, is_ctrl_char(c), 1'b0, 1'b0});
  endtask

  task automatic emit_literal(input logic [7:0] b);
    prev_older = prev_newest;
    prev_newest = b;
    item_results.push_back(slot_t'{b, 1'b1, 1'b0, 1'b0, 1'b0});
  endtask

  // Works out every result that one accepted item causes.
  task automatic code_item(input logic [7:0] b, input logic eot);
    logic [7:0] s;
    logic [7:0] c;
    logic       amb;
    slot_t      tail;
    item_results.delete();
    if (encode_mode) begin
      if (eot) begin
        if (!enc_halted) item_results.push_back(slot_t'{CH_LF, 1'b1, 1'b0, 1'b0, 1'b1});
        clear_text();
        return;
      end
      if (enc_halted) return;
      if (b == CH_LF) begin
        emit_literal(CH_LT);
        emit_literal(CH_E);
        emit_literal(CH_GT);
        if (lf_marks != 8'd255) lf_marks = lf_marks + 8'd1;
        if (lf_marks >= period_reg) begin
          emit_literal(CH_LF);
          lf_marks = 8'd0;
        end
        return;
      end
      s = live_step();
      c = rotate_char(b, s, 1'b1);
      amb = (c == CH_LF) || (prev_older == CH_LT && prev_newest == CH_E && c == CH_GT);
      bump_step(s);
      prev_older = prev_newest;
      prev_newest = c;
      if (amb) enc_halted = 1'b1;
      item_results.push_back(slot_t'{c, 1'b1, is_ctrl_char(b), amb, amb});
      return;
    end

    if (eot) begin
      if (marker_held >= 2'd1) decode_char(CH_LT);
      if (marker_held >= 2'd2) decode_char(CH_E);
      if (item_results.size() == 0) begin
        item_results.push_back(slot_t'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1});
      end else begin
        tail = item_results.pop_back();
        tail.last = 1'b1;
        item_results.push_back(tail);
      end
      clear_text();
      return;
    end

    // A held marker that the new byte does not complete goes out as ordinary text.
    if (marker_held == 2'd1) begin
      if (b == CH_E) begin
        marker_held = 2'd2;
        return;
      end
      decode_char(CH_LT);
      marker_held = 2'd0;
    end else if (marker_held >= 2'd2) begin
      if (b == CH_GT) begin
        marker_held = 2'd0;
        item_results.push_back(slot_t'{CH_LF, 1'b1, 1'b0, 1'b0, 1'b0});
        return;
      end
      decode_char(CH_LT);
      decode_char(CH_E);
      marker_held = 2'd0;
    end
    if (b == CH_LF) return;
    if (b == CH_LT) begin
      marker_held = 2'd1;
      return;
    end
    decode_char(b);
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    slot_t want;
    if (rst) begin
      period_reg = 8'd6;
      encode_mode = DIR_DECODE;
      clear_text();
      expected_out.delete();
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_index)
          REG_PERIOD:    period_reg = cfg_data;
          REG_DIRECTION: encode_mode = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (!(encode_mode && enc_halted && !end_of_text)) coded_items++;
        code_item(data_byte, end_of_text);
        if (pin_valid) begin
          expected_out.push_back(pin_result);
        end else begin
          foreach (item_results[k]) expected_out.push_back(item_results[k]);
        end
      end

      if (out_valid && !out_stall) begin
        checked_results++;
        if (expected_out.size() == 0) begin
          mismatches++;
          $display("%0t: result %0h arrived with nothing expected", $time, out_byte);
        end else begin
          want = expected_out.pop_front();
          check_field("out_byte", want.value, out_byte);
          check_field("has_byte", 8'(want.has), 8'(has_byte));
          check_field("ctrl_char", 8'(want.ctrl), 8'(ctrl_char));
          check_field("status", 8'(want.stat), 8'(status));
          check_field("last", 8'(want.last), 8'(last));
        end
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        repeat (LongHold) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot = 1'b0,
                           input logic pinned = 1'b0, input slot_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_text <= eot;
    pin_valid <= pinned;
    pin_result <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the block run dry; an item may still be in flight without any result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly well-formed text: whole markers, broken markers, newlines, printables and arbitrary bytes.
  task automatic send_text(input int len, input logic close);
    int pick;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        send_item(CH_LT);
        send_item(CH_E);
        send_item(CH_GT);
      end else if (pick < 26) begin
        send_item(CH_LT);
        if (pick < 22) send_item(CH_E);
        send_item(8'($urandom_range(255)));
      end else if (pick < 38) begin
        send_item(CH_LF);
      end else if (pick < 75) begin
        send_item(8'($urandom_range(126, 32)));
      end else begin
        send_item(8'($urandom_range(255)));
      end
    end
    if (close) send_item(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int         goal;
    logic [7:0] per;
    logic       dir_bit;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumRows; r++) begin
      case (Plan[r].kind)
        ROW_ITEM: send_item(Plan[r].value, Plan[r].eot, Plan[r].pinned, Plan[r].want);
        ROW_PERIOD: begin
          settle();
          write_reg(REG_PERIOD, Plan[r].value);
        end
        ROW_DIRECTION: begin
          settle();
          write_reg(REG_DIRECTION, Plan[r].value);
        end
        default: ;
      endcase
    end

    // Texts are sometimes left open across a phase change, so state carries over.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: per = 8'd255;
        1: per = 8'd1;
        2: per = 8'd0;
        7: per = 8'($urandom_range(255));
        default: per = 8'($urandom_range(12, 1));
      endcase
      dir_bit = (ph < 4) ? ph[0] : 1'($urandom_range(1));
      write_reg(REG_PERIOD, per);
      write_reg(REG_DIRECTION, {7'd0, dir_bit});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      goal = coded_items + PhaseItems;
      while (coded_items < goal) send_text($urandom_range(10, 2), $urandom_range(3) != 0);
    end

    // Every newline expands to four bytes here, so a long output hold backs up the input.
    settle();
    write_reg(REG_DIRECTION, {7'd0, DIR_ENCODE});
    write_reg(REG_PERIOD, 8'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(8'h00, 1'b1);
    hold_requests++;
    repeat (16) send_item(CH_LF);
    send_item(8'($urandom_range(255)), 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (2 * SettleCycles) @(posedge clk);

    $display("Coded %0d items in both directions over %0d register writes, periods 0 to 255,",
             coded_items, cfg_writes);
    $display("with markers, newline grouping, ambiguity and a long output hold; %0d results.",
             checked_results);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cstc_pkg.sv
sv/cstc_front.sv
sv/cstc_fifo.sv
sv/cstc_back.sv
sv/cyclic_shift_text_codec_core.sv
verif/tb.sv
